/* rtl/dq_pkg.sv */
// Package for the double-ended queue: word field widths, request kinds,
// status codes and sequencer states. No dependencies.
package dq_pkg;

    localparam int KIND_W   = 4;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_BACK  = 4'd0,
        K_PUSH_FRONT = 4'd1,
        K_POP_FRONT  = 4'd2,
        K_POP_BACK   = 4'd3,
        K_READ       = 4'd4,
        K_REMOVE     = 4'd5,
        K_PEEK_FRONT = 4'd6,
        K_PEEK_BACK  = 4'd7,
        K_CLEAR      = 4'd8
    } dq_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } dq_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_RM_RD,
        S_RM_WR,
        S_PF_RD,
        S_PF_WR,
        S_PF_HEAD,
        S_DONE
    } dq_state_t;

endpackage

/* rtl/dq_req_if.sv */
// Request channel of the double-ended queue: valid/ready and the request word.
// Depends on dq_pkg for field widths.
interface dq_req_if import dq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] data_in;
    logic [POS_W-1:0]  position;

    modport source (output valid, output kind, output data_in, output position,
                    input ready);
    modport sink   (input valid, input kind, input data_in, input position,
                    output ready);
endinterface

/* rtl/dq_rsp_if.sv */
// Result channel of the double-ended queue: valid/ready and the result word.
// Depends on dq_pkg for field widths.
interface dq_rsp_if import dq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   data_out;
    logic                data_valid;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output data_out, output data_valid,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input data_out, input data_valid,
                    input status, input entry_count, output ready);
endinterface

/* rtl/dq_store.sv */
// Entry store of the double-ended queue: one write port, one read port
// with registered read data. No dependencies.
module dq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]    rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue: request sequencer and result register.
// Depends on dq_pkg, dq_req_if, dq_rsp_if and dq_store.
//
// Usage:
//   req carries one request word (kind, data_in, position); rsp returns one
//   result word (data_out, data_valid, status, entry_count) per request.
//   Words move when valid and ready are both high at a rising edge of clk.
//   One request is in work at a time; req.ready is high only while the
//   sequencer waits for a request. A result word waits in its output
//   register and the next request is taken meanwhile.
// Sequencing:
//   Push back, clear, peek, read, pop back and failed requests move no other
//   entry. Push front moves every entry up by one place; remove and pop front
//   move down every entry behind the one taken. Every entry moved is one read
//   and one write on the store, through the state pairs S_PF_RD/S_PF_WR and
//   S_RM_RD/S_RM_WR.
// Reset:
//   rst_n clears the entry count, the sequencer and the output valid flag;
//   the store itself is not cleared and is read only below the count.
// Stall:
//   while an earlier result waits and rsp.ready is low, a finished result
//   holds the sequencer in its final state; the waiting result word stays on rsp.
module double_ended_queue import dq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    dq_state_t             state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  res_dv_reg, res_dv_next;
    dq_status_t            res_status_reg, res_status_next;
    logic [WORD_W-1:0]     out_data_reg, out_data_next;
    logic                  out_dv_reg, out_dv_next;
    dq_status_t            out_status_reg, out_status_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  req_accept;
    logic                  out_free;
    logic                  empty;
    logic                  full;
    logic                  pos_miss;
    logic                  is_push;
    logic                  is_fetch;
    logic                  is_back;
    logic                  is_remover;
    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         idx_dec;
    logic [CW-1:0]         count_dec;
    logic                  fetch_last;
    logic                  rm_last;
    logic [CW-1:0]         target;
    logic [63:0]           in_wide;
    logic [63:0]           word_wide;
    logic [31:0]           count_wide;

    dq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CW'(DEPTH));
    assign pos_miss   = CMPW'(pos_reg) >= CMPW'(count_reg);
    assign is_push    = (kind_reg == K_PUSH_BACK) || (kind_reg == K_PUSH_FRONT);
    assign is_fetch   = (kind_reg == K_POP_FRONT) || (kind_reg == K_POP_BACK)
                     || (kind_reg == K_PEEK_FRONT) || (kind_reg == K_PEEK_BACK);
    assign is_back    = (kind_reg == K_POP_BACK) || (kind_reg == K_PEEK_BACK);
    assign is_remover = (kind_reg == K_POP_FRONT) || (kind_reg == K_POP_BACK)
                     || (kind_reg == K_REMOVE);
    assign idx_inc    = idx_reg + CW'(1);
    assign idx_dec    = idx_reg - CW'(1);
    assign count_dec  = count_reg - CW'(1);
    assign fetch_last = (idx_inc == count_reg);
    assign rm_last    = ((idx_reg + CW'(2)) == count_reg);
    assign target     = is_fetch ? (is_back ? count_dec : '0) : CW'(pos_reg);

    assign in_wide    = {32'b0, req.data_in};
    assign word_wide  = 64'(word_reg);
    assign count_wide = 32'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (is_push)
                begin
                    if (full || kind_reg == K_PUSH_BACK || empty)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PF_RD;
                    end
                end
                else if (is_fetch)
                begin
                    state_next = empty ? S_DONE : S_FETCH;
                end
                else if (kind_reg == K_READ || kind_reg == K_REMOVE)
                begin
                    state_next = pos_miss ? S_DONE : S_FETCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                state_next = (is_remover && !fetch_last) ? S_RM_RD : S_DONE;
            end
            S_RM_RD:
            begin
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                state_next = rm_last ? S_DONE : S_RM_RD;
            end
            S_PF_RD:
            begin
                state_next = S_PF_WR;
            end
            S_PF_WR:
            begin
                state_next = (idx_reg == CW'(1)) ? S_PF_HEAD : S_PF_RD;
            end
            S_PF_HEAD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        kind_next       = kind_reg;
        word_next       = word_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        res_dv_next     = res_dv_reg;
        res_status_next = res_status_reg;
        out_data_next   = out_data_reg;
        out_dv_next     = out_dv_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    kind_next = req.kind;
                    word_next = in_wide[DATA_WIDTH-1:0];
                    pos_next  = req.position;
                end
            end
            S_EXEC:
            begin
                res_dv_next     = 1'b0;
                res_status_next = ST_OK;
                if (is_push)
                begin
                    if (full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else if (kind_reg == K_PUSH_BACK || empty)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        wr_data    = word_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        idx_next = count_reg;
                    end
                end
                else if (is_fetch || kind_reg == K_READ || kind_reg == K_REMOVE)
                begin
                    if ((is_fetch && empty) || (!is_fetch && pos_miss))
                    begin
                        res_status_next = ST_MISS;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = target[AW-1:0];
                        idx_next    = target;
                        res_dv_next = 1'b1;
                    end
                end
                else if (kind_reg == K_CLEAR)
                begin
                    count_next = '0;
                end
            end
            S_FETCH:
            begin
                word_next = rd_data;
                if (is_remover && fetch_last)
                begin
                    count_next = count_dec;
                end
            end
            S_RM_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_inc[AW-1:0];
            end
            S_RM_WR:
            begin
                wr_en = 1'b1;
                if (rm_last)
                begin
                    count_next = count_dec;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_PF_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_dec[AW-1:0];
            end
            S_PF_WR:
            begin
                wr_en = 1'b1;
                if (idx_reg != CW'(1))
                begin
                    idx_next = idx_dec;
                end
            end
            S_PF_HEAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = word_reg;
                count_next = count_reg + CW'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_dv_reg ? word_wide[WORD_W-1:0] : '0;
                    out_dv_next     = res_dv_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_wide[COUNT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        word_reg       <= word_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        res_dv_reg     <= res_dv_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_dv_reg     <= out_dv_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.data_out    = out_data_reg;
    assign rsp.data_valid  = out_dv_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> state_reg == S_EXEC)
        else $error("accepted request not taken into work");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data_valid) |-> rsp.status == ST_OK)
        else $error("result carries an entry with a failing status");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.data_valid) |-> rsp.data_out == '0)
        else $error("result without entry carries nonzero data");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RM_WR) |-> idx_inc < count_reg)
        else $error("remove shift beyond last entry");

endmodule
